### rtl/hbs_pkg.sv
// Shared constants and types for the heightmap bilinear sampler.
package hbs_pkg;

  localparam int DATA_W       = 32;
  localparam int SEG_W        = 6;
  localparam int GRID_AW      = 12;
  localparam int GRID_DEPTH   = 1 << GRID_AW;
  localparam int MAX_SEGMENTS = 63;

  // Grid position p = floor(pos * seg / 300) in Q14.16.
  localparam int FRAC_W  = 16;
  localparam int CELL_W  = 14;               // signed integer part of p
  localparam int PROD_W  = DATA_W + SEG_W + 1; // pos * seg, signed
  localparam int MAG_W   = 35;               // magnitude of the product divided by 4
  localparam int QUOT_W  = 29;               // floor(mag / 75)
  localparam int POS_W   = QUOT_W + 1;       // signed grid position

  // floor(v / 75) = (v * RECIP_M) >> RECIP_SHIFT, low by at most one for v < 2^35
  localparam int          RECIP_W     = 30;
  localparam int          RECIP_SHIFT = 36;
  localparam logic [29:0] RECIP_M     = 30'd916259689;
  localparam int          CELL_DIV    = 75;  // 300 / 4
  localparam int          SPLIT_LO    = 18;  // low slice of the magnitude per partial product

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic [GRID_AW-1:0] ll;
    logic [GRID_AW-1:0] lr;
    logic [GRID_AW-1:0] ul;
    logic [GRID_AW-1:0] ur;
  } hbs_corner_addr_t;

  typedef struct packed {
    logic [DATA_W-1:0] ll;
    logic [DATA_W-1:0] lr;
    logic [DATA_W-1:0] ul;
    logic [DATA_W-1:0] ur;
  } hbs_corner_data_t;

endpackage

### rtl/hbs_axis_scale.sv
// Four-stage scaling of one coordinate to grid units: cell index and fraction.
module hbs_axis_scale (
  input  logic                                 clk,
  input  logic [3:0]                           ld,
  input  logic signed [hbs_pkg::DATA_W-1:0]    pos,
  input  logic [hbs_pkg::SEG_W-1:0]            seg,
  output logic signed [hbs_pkg::CELL_W-1:0]    cell_idx,
  output logic [hbs_pkg::FRAC_W-1:0]           frac
);

  localparam int PL_W  = hbs_pkg::SPLIT_LO + hbs_pkg::RECIP_W;
  localparam int PH_W  = hbs_pkg::MAG_W - hbs_pkg::SPLIT_LO + hbs_pkg::RECIP_W;
  localparam int SUM_W = PH_W + hbs_pkg::SPLIT_LO + 1;
  localparam int REM_W = hbs_pkg::MAG_W + 1;

  logic signed [hbs_pkg::PROD_W-1:0] prod_nxt;
  logic [hbs_pkg::PROD_W-1:0]        mag_nxt;
  logic [hbs_pkg::MAG_W-1:0]         mag_a_r;
  logic                              neg_a_r;

  logic [PL_W-1:0]                   pl_nxt;
  logic [PH_W-1:0]                   ph_nxt;
  logic [PL_W-1:0]                   pl_b_r;
  logic [PH_W-1:0]                   ph_b_r;
  logic [hbs_pkg::MAG_W-1:0]         mag_b_r;
  logic                              neg_b_r;

  logic [SUM_W-1:0]                  full_nxt;
  logic [hbs_pkg::QUOT_W-1:0]        qe_c_r;
  logic [hbs_pkg::MAG_W-1:0]         mag_c_r;
  logic                              neg_c_r;

  logic [REM_W-1:0]                  back_nxt;
  logic [REM_W-1:0]                  rem_nxt;
  logic [hbs_pkg::QUOT_W-1:0]        q_nxt;
  logic [hbs_pkg::POS_W-1:0]         p_nxt;
  logic signed [hbs_pkg::CELL_W-1:0] cell_r;
  logic [hbs_pkg::FRAC_W-1:0]        frac_r;

  // Floor division of a negative n is ~floor(~n / d); 300 = 4 * 75.
  assign prod_nxt = pos * $signed({1'b0, seg});
  assign mag_nxt  = prod_nxt[hbs_pkg::PROD_W-1] ? ~prod_nxt : prod_nxt;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      mag_a_r <= mag_nxt[hbs_pkg::MAG_W+1:2];
      neg_a_r <= prod_nxt[hbs_pkg::PROD_W-1];
    end
  end

  // reciprocal multiply split in two partial products
  assign pl_nxt = PL_W'(mag_a_r[hbs_pkg::SPLIT_LO-1:0]) * PL_W'(hbs_pkg::RECIP_M);
  assign ph_nxt = PH_W'(mag_a_r[hbs_pkg::MAG_W-1:hbs_pkg::SPLIT_LO]) *
                  PH_W'(hbs_pkg::RECIP_M);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      pl_b_r  <= pl_nxt;
      ph_b_r  <= ph_nxt;
      mag_b_r <= mag_a_r;
      neg_b_r <= neg_a_r;
    end
  end

  assign full_nxt = SUM_W'({ph_b_r, {hbs_pkg::SPLIT_LO{1'b0}}}) + SUM_W'(pl_b_r);

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      qe_c_r  <= full_nxt[hbs_pkg::RECIP_SHIFT+hbs_pkg::QUOT_W-1:hbs_pkg::RECIP_SHIFT];
      mag_c_r <= mag_b_r;
      neg_c_r <= neg_b_r;
    end
  end

  // estimate may be one short: fix with one compare
  assign back_nxt = REM_W'(qe_c_r) * REM_W'(hbs_pkg::CELL_DIV);
  assign rem_nxt  = REM_W'(mag_c_r) - back_nxt;
  assign q_nxt    = (rem_nxt >= REM_W'(hbs_pkg::CELL_DIV)) ?
                    qe_c_r + hbs_pkg::QUOT_W'(1) : qe_c_r;
  assign p_nxt    = neg_c_r ? ~{1'b0, q_nxt} : {1'b0, q_nxt};

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      cell_r <= $signed(p_nxt[hbs_pkg::POS_W-1:hbs_pkg::FRAC_W]);
      frac_r <= p_nxt[hbs_pkg::FRAC_W-1:0];
    end
  end

  assign cell_idx = cell_r;
  assign frac     = frac_r;

endmodule

### rtl/hbs_grid_mem.sv
// Height grid storage: two copies, each with one write and two registered read ports.
module hbs_grid_mem (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [hbs_pkg::GRID_AW-1:0]       wr_addr,
  input  logic [hbs_pkg::DATA_W-1:0]        wr_data,
  input  logic                              rd_en,
  input  hbs_pkg::hbs_corner_addr_t         rd_addr,
  output hbs_pkg::hbs_corner_data_t         rd_data
);

  logic [hbs_pkg::DATA_W-1:0] row0_mem_r [hbs_pkg::GRID_DEPTH];
  logic [hbs_pkg::DATA_W-1:0] row1_mem_r [hbs_pkg::GRID_DEPTH];
  hbs_pkg::hbs_corner_data_t  rd_data_r;

  // lower row corners come from one copy, upper row corners from the other
  always_ff @(posedge clk) begin
    if (wr_en) begin
      row0_mem_r[wr_addr] <= wr_data;
      row1_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r.ll <= row0_mem_r[rd_addr.ll];
      rd_data_r.lr <= row0_mem_r[rd_addr.lr];
      rd_data_r.ul <= row1_mem_r[rd_addr.ul];
      rd_data_r.ur <= row1_mem_r[rd_addr.ur];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/heightmap_bilinear_sampler_core.sv
// Top level: bilinear height sampler pipeline over a square terrain tile grid.
// Takes one item per clock while in_ready is high and holds a 13-stage
// pipeline: out_valid for a query rises when the item reaches stage 13, and
// the result is taken while out_ready is high. Each stage holds its item
// until the next stage is free, so bubbles close up and in_ready only drops
// when every stage is full. Write items store their sample in the grid at
// stage 8, in order with the queries around them, and produce no result. The
// grid is kept in two copies with two read ports each so that all four corners
// are read in the same cycle; its contents are undefined after reset and there
// is no clear pass. segments may only change while the pipeline is empty.
module heightmap_bilinear_sampler_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [hbs_pkg::SEG_W-1:0]        cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic signed [hbs_pkg::DATA_W-1:0] in_x_pos,
  input  logic signed [hbs_pkg::DATA_W-1:0] in_y_pos,
  input  logic signed [hbs_pkg::DATA_W-1:0] in_z_offset,
  input  logic [hbs_pkg::GRID_AW-1:0]      in_grid_index,
  input  logic signed [hbs_pkg::DATA_W-1:0] in_sample_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [hbs_pkg::DATA_W-1:0] out_height
);

  localparam int NSTG    = 13;
  localparam int MEM_STG = 8;
  localparam int DW      = hbs_pkg::DATA_W;
  localparam int SW      = hbs_pkg::SEG_W;
  localparam int MUL_W   = DW + 1 + hbs_pkg::FRAC_W + 1;
  localparam int ROW_W   = 2 * SW + 1;

  logic [SW-1:0]                  seg_r;
  logic [SW-1:0]                  seg_eff;
  logic [SW:0]                    stride;

  logic [NSTG:1]                  vld_r;
  logic [NSTG+1:1]                ld;

  logic                           op_r   [1:MEM_STG-1];
  logic [hbs_pkg::GRID_AW-1:0]    gidx_r [1:MEM_STG-1];
  logic [DW-1:0]                  sval_r [1:MEM_STG-1];
  logic [DW-1:0]                  z_r    [1:NSTG-1];
  logic signed [DW-1:0]           x1_r;
  logic signed [DW-1:0]           y1_r;

  logic signed [hbs_pkg::CELL_W-1:0] cx5;
  logic signed [hbs_pkg::CELL_W-1:0] cy5;
  logic [hbs_pkg::FRAC_W-1:0]     tx5;
  logic [hbs_pkg::FRAC_W-1:0]     ty5;
  logic [hbs_pkg::FRAC_W-1:0]     tx_r [6:MEM_STG];
  logic [hbs_pkg::FRAC_W-1:0]     ty_r [6:10];

  logic [SW-1:0]                  x0_r, x1c_r, y0_r, y1c_r;
  logic [ROW_W-1:0]               row0_nxt, row1_nxt;
  hbs_pkg::hbs_corner_addr_t      addr_r;
  hbs_pkg::hbs_corner_data_t      corner;
  logic                           mem_wr_en;

  logic signed [DW:0]             dl_nxt, dh_nxt, dv_nxt;
  logic signed [MUL_W-1:0]        dlo_r, dhi_r, dd_r;
  logic [DW-1:0]                  ll9_r, ul9_r;
  logic signed [MUL_W-1:0]        rlo_nxt, rhi_nxt, rdd_nxt;
  logic [DW-1:0]                  lo10_r, hi10_r, lo11_r, bl12_r;
  logic signed [DW:0]             sum_nxt;
  logic [DW-1:0]                  height_r;

  function automatic logic [hbs_pkg::SEG_W-1:0] clamp_cell(
    input logic signed [hbs_pkg::CELL_W:0] c,
    input logic [hbs_pkg::SEG_W-1:0]       hi
  );
    logic [hbs_pkg::SEG_W-1:0] res;
    priority if (c < 0) begin
      res = '0;
    end else if (c > $signed({{(hbs_pkg::CELL_W-hbs_pkg::SEG_W+1){1'b0}}, hi})) begin
      res = hi;
    end else begin
      res = c[hbs_pkg::SEG_W-1:0];
    end
    return res;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= SW'(1);
    end else if (cfg_wr_en) begin
      seg_r <= cfg_wr_data;
    end
  end

  assign seg_eff = (seg_r > SW'(hbs_pkg::MAX_SEGMENTS)) ? SW'(hbs_pkg::MAX_SEGMENTS) : seg_r;
  assign stride  = {1'b0, seg_eff} + (SW+1)'(1);

  // a stage takes a new item when it is empty or its item moves on
  assign ld[NSTG+1] = out_ready;
  for (genvar k = 1; k <= NSTG; k++) begin : g_ld
    assign ld[k] = ~vld_r[k] | ld[k+1];
  end
  assign in_ready = ld[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (ld[k] && k != MEM_STG) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      // write items end at the grid
      if (ld[MEM_STG]) begin
        vld_r[MEM_STG] <= vld_r[MEM_STG-1] & (op_r[MEM_STG-1] == hbs_pkg::OP_QUERY);
      end
    end
  end

  // stage 1 and payload carried along
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      op_r[1]   <= in_operation;
      gidx_r[1] <= in_grid_index;
      sval_r[1] <= in_sample_value;
      z_r[1]    <= in_z_offset;
      x1_r      <= in_x_pos;
      y1_r      <= in_y_pos;
    end
    for (int k = 2; k < MEM_STG; k++) begin
      if (ld[k]) begin
        op_r[k]   <= op_r[k-1];
        gidx_r[k] <= gidx_r[k-1];
        sval_r[k] <= sval_r[k-1];
      end
    end
    for (int k = 2; k < NSTG; k++) begin
      if (ld[k]) begin
        z_r[k] <= z_r[k-1];
      end
    end
  end

  // stages 2..5: scale to grid units
  hbs_axis_scale u_scale_x (
    .clk      (clk),
    .ld       (ld[5:2]),
    .pos      (x1_r),
    .seg      (seg_eff),
    .cell_idx (cx5),
    .frac     (tx5)
  );

  hbs_axis_scale u_scale_y (
    .clk      (clk),
    .ld       (ld[5:2]),
    .pos      (y1_r),
    .seg      (seg_eff),
    .cell_idx (cy5),
    .frac     (ty5)
  );

  // stage 6: clamp corners to the tile, fraction stays unclamped
  always_ff @(posedge clk) begin
    if (ld[6]) begin
      x0_r    <= clamp_cell({cx5[hbs_pkg::CELL_W-1], cx5}, seg_eff);
      x1c_r   <= clamp_cell({cx5[hbs_pkg::CELL_W-1], cx5} + (hbs_pkg::CELL_W+1)'(1), seg_eff);
      y0_r    <= clamp_cell({cy5[hbs_pkg::CELL_W-1], cy5}, seg_eff);
      y1c_r   <= clamp_cell({cy5[hbs_pkg::CELL_W-1], cy5} + (hbs_pkg::CELL_W+1)'(1), seg_eff);
      tx_r[6] <= tx5;
      ty_r[6] <= ty5;
    end
  end

  // stage 7: linear addresses
  assign row0_nxt = ROW_W'(y0_r) * ROW_W'(stride);
  assign row1_nxt = ROW_W'(y1c_r) * ROW_W'(stride);

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      addr_r.ll <= hbs_pkg::GRID_AW'(row0_nxt + ROW_W'(x0_r));
      addr_r.lr <= hbs_pkg::GRID_AW'(row0_nxt + ROW_W'(x1c_r));
      addr_r.ul <= hbs_pkg::GRID_AW'(row1_nxt + ROW_W'(x0_r));
      addr_r.ur <= hbs_pkg::GRID_AW'(row1_nxt + ROW_W'(x1c_r));
      tx_r[7]   <= tx_r[6];
      ty_r[7]   <= ty_r[6];
    end
    if (ld[MEM_STG]) begin
      tx_r[MEM_STG] <= tx_r[7];
      ty_r[MEM_STG] <= ty_r[7];
    end
    if (ld[9]) begin
      ty_r[9] <= ty_r[MEM_STG];
    end
    if (ld[10]) begin
      ty_r[10] <= ty_r[9];
    end
  end

  // stage 8: grid read, or the write of a write item
  assign mem_wr_en = ld[MEM_STG] & vld_r[MEM_STG-1] &
                     (op_r[MEM_STG-1] == hbs_pkg::OP_WRITE);

  hbs_grid_mem u_grid (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (gidx_r[MEM_STG-1]),
    .wr_data (sval_r[MEM_STG-1]),
    .rd_en   (ld[MEM_STG]),
    .rd_addr (addr_r),
    .rd_data (corner)
  );

  // stage 9: horizontal blend products
  assign dl_nxt = $signed({corner.lr[DW-1], corner.lr}) - $signed({corner.ll[DW-1], corner.ll});
  assign dh_nxt = $signed({corner.ur[DW-1], corner.ur}) - $signed({corner.ul[DW-1], corner.ul});

  always_ff @(posedge clk) begin
    if (ld[9]) begin
      dlo_r <= dl_nxt * $signed({1'b0, tx_r[MEM_STG]});
      dhi_r <= dh_nxt * $signed({1'b0, tx_r[MEM_STG]});
      ll9_r <= corner.ll;
      ul9_r <= corner.ul;
    end
  end

  // stage 10: round to nearest (half up), add base
  assign rlo_nxt = dlo_r + MUL_W'(32768);
  assign rhi_nxt = dhi_r + MUL_W'(32768);

  always_ff @(posedge clk) begin
    if (ld[10]) begin
      lo10_r <= ll9_r + rlo_nxt[DW+hbs_pkg::FRAC_W-1:hbs_pkg::FRAC_W];
      hi10_r <= ul9_r + rhi_nxt[DW+hbs_pkg::FRAC_W-1:hbs_pkg::FRAC_W];
    end
  end

  // stage 11: vertical blend product
  assign dv_nxt = $signed({hi10_r[DW-1], hi10_r}) - $signed({lo10_r[DW-1], lo10_r});

  always_ff @(posedge clk) begin
    if (ld[11]) begin
      dd_r   <= dv_nxt * $signed({1'b0, ty_r[10]});
      lo11_r <= lo10_r;
    end
  end

  // stage 12
  assign rdd_nxt = dd_r + MUL_W'(32768);

  always_ff @(posedge clk) begin
    if (ld[12]) begin
      bl12_r <= lo11_r + rdd_nxt[DW+hbs_pkg::FRAC_W-1:hbs_pkg::FRAC_W];
    end
  end

  // stage 13: add offset, saturate
  assign sum_nxt = $signed({bl12_r[DW-1], bl12_r}) + $signed({z_r[12][DW-1], z_r[12]});

  always_ff @(posedge clk) begin
    if (ld[NSTG]) begin
      if (sum_nxt[DW] != sum_nxt[DW-1]) begin
        height_r <= sum_nxt[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
        height_r <= sum_nxt[DW-1:0];
      end
    end
  end

  assign out_valid  = vld_r[NSTG];
  assign out_height = height_r;

endmodule

### dv/hbs_height_checker.sv
// Checker for the heightmap sampler: mirrors the grid, predicts each height and compares results.
module hbs_height_checker
  import hbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [SEG_W-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_operation,
  input  logic signed [DATA_W-1:0] in_x_pos,
  input  logic signed [DATA_W-1:0] in_y_pos,
  input  logic signed [DATA_W-1:0] in_z_offset,
  input  logic [GRID_AW-1:0]       in_grid_index,
  input  logic signed [DATA_W-1:0] in_sample_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] out_height,
  output int                       outstanding,
  output int                       checked,
  output int                       errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TILE_M = 300;
  localparam longint HALF   = 1 << (FRAC_W - 1);
  localparam longint H_MAX  = (longint'(1) <<< 31) - 1;
  localparam longint H_MIN  = -(longint'(1) <<< 31);

  logic [SEG_W-1:0]         seg_setting;
  logic signed [DATA_W-1:0] grid_copy [GRID_DEPTH];
  logic signed [DATA_W-1:0] height_due [$];

  // C-style truncating divide corrected toward minus infinity
  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if (n % d != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic longint clamp_cell(longint c, longint hi);
    if (c < 0) return 0;
    if (c > hi) return hi;
    return c;
  endfunction

  function automatic longint mix(longint a, longint b, longint t);
    return a + (((b - a) * t + HALF) >>> FRAC_W);
  endfunction

  function automatic longint corner(longint row, longint col, longint stride);
    logic [GRID_AW-1:0] idx;
    idx = GRID_AW'(row * stride + col);
    return longint'(grid_copy[idx]);
  endfunction

  function automatic logic signed [DATA_W-1:0] interp_height(
    logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] y, logic signed [DATA_W-1:0] z);
    longint seg, stride, px, py, cx, cy, tx, ty, x0, x1, y0, y1, lo, hi, h;
    seg = (seg_setting > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_setting;
    stride = seg + 1;
    px = floor_quot(longint'(x) * seg, TILE_M);
    py = floor_quot(longint'(y) * seg, TILE_M);
    cx = px >>> FRAC_W;
    cy = py >>> FRAC_W;
    // fraction comes from the unclamped position
    tx = px - (cx <<< FRAC_W);
    ty = py - (cy <<< FRAC_W);
    x0 = clamp_cell(cx, seg);
    x1 = clamp_cell(cx + 1, seg);
    y0 = clamp_cell(cy, seg);
    y1 = clamp_cell(cy + 1, seg);
    lo = mix(corner(y0, x0, stride), corner(y0, x1, stride), tx);
    hi = mix(corner(y1, x0, stride), corner(y1, x1, stride), tx);
    h = mix(lo, hi, ty) + longint'(z);
    if (h > H_MAX) h = H_MAX;
    if (h < H_MIN) h = H_MIN;
    return DATA_W'(h);
  endfunction

  task automatic flag_mismatch(string what, logic signed [DATA_W-1:0] want,
                               logic signed [DATA_W-1:0] got);
    $display("[%0t] height mismatch (%s): expected %h got %h", $realtime, what, want, got);
    errors += 1;
  endtask

  always @(posedge clk) begin
    logic signed [DATA_W-1:0] want;
    if (!rst_n) begin
      seg_setting <= SEG_W'(1);
      height_due.delete();
      outstanding <= 0;
    end else begin
      if (cfg_wr_en) seg_setting <= cfg_wr_data;
      if (in_valid && in_ready) begin
        if (in_operation == OP_WRITE) begin
          grid_copy[in_grid_index] = in_sample_value;
        end else begin
          height_due.push_back(interp_height(in_x_pos, in_y_pos, in_z_offset));
        end
      end
      if (out_valid && out_ready) begin
        if (height_due.size() == 0) begin
          flag_mismatch("no query pending", 'x, out_height);
        end else begin
          want = height_due.pop_front();
          checked += 1;
          if (out_height !== want) flag_mismatch("height", want, out_height);
        end
      end
      outstanding <= height_due.size();
    end
  end

endmodule

### dv/heightmap_bilinear_sampler_core_test.sv
// Testbench top: loads grid samples, streams height queries and reports the verdict.
module heightmap_bilinear_sampler_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hbs_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 30;
  localparam int STALL_LIMIT  = 3000;
  localparam int TILE_Q       = 300 << FRAC_W;

  localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] ONE_M = 32'sh0001_0000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [SEG_W-1:0]         cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_operation = OP_QUERY;
  logic signed [DATA_W-1:0] in_x_pos = '0;
  logic signed [DATA_W-1:0] in_y_pos = '0;
  logic signed [DATA_W-1:0] in_z_offset = '0;
  logic [GRID_AW-1:0]       in_grid_index = '0;
  logic signed [DATA_W-1:0] in_sample_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_height;

  int outstanding, checked, errors;
  int seg_now = 1;
  int burst_left = 0;
  int n_query = 0, n_write = 0, n_settings = 0;
  bit hold_req = 1'b0;
  bit written [GRID_DEPTH];
  int unsigned seg_plan [8] = '{0, 20, 2, 17, 1, 13, 5, 9};

  heightmap_bilinear_sampler_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_z_offset     (in_z_offset),
    .in_grid_index   (in_grid_index),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_height      (out_height)
  );

  hbs_height_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_z_offset     (in_z_offset),
    .in_grid_index   (in_grid_index),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_height      (out_height),
    .outstanding     (outstanding),
    .checked         (checked),
    .errors          (errors)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic signed [DATA_W-1:0] rand_height();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return S_MAX;
          1: return S_MIN;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return $urandom_range(0, 2000 << FRAC_W) - (1000 << FRAC_W);
    endcase
  endfunction

  // mostly inside the tile, some just past the edges, some anywhere
  function automatic logic signed [DATA_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return $urandom_range(0, TILE_Q + (40 << FRAC_W)) - (20 << FRAC_W);
      2: begin
        case ($urandom_range(0, 3))
          0: return TILE_Q;
          1: return TILE_Q - 1;
          2: return -1;
          default: return '0;
        endcase
      end
      default: return $urandom_range(0, TILE_Q);
    endcase
  endfunction

  task automatic send_item(input logic op, input logic signed [DATA_W-1:0] x,
                           input logic signed [DATA_W-1:0] y,
                           input logic signed [DATA_W-1:0] z,
                           input logic [GRID_AW-1:0] idx,
                           input logic signed [DATA_W-1:0] val);
    int gap;
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_x_pos        <= x;
    in_y_pos        <= y;
    in_z_offset     <= z;
    in_grid_index   <= idx;
    in_sample_value <= val;
    do @(posedge clk); while (!in_ready);
    if (op == OP_WRITE) begin
      written[idx] = 1'b1;
      n_write++;
    end else begin
      n_query++;
    end
    // bursty sender: random gap once the current burst runs out
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic query(input logic signed [DATA_W-1:0] x, input logic signed [DATA_W-1:0] y,
                       input logic signed [DATA_W-1:0] z);
    send_item(OP_QUERY, x, y, z, GRID_AW'($urandom), $urandom);
  endtask

  task automatic store(input logic [GRID_AW-1:0] idx, input logic signed [DATA_W-1:0] val);
    send_item(OP_WRITE, $urandom, $urandom, $urandom, idx, val);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    // the count from the checker is registered, so it lags the last accepted item
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // trailing grid writes carry no result; let them leave the pipe
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_segments(input int unsigned seg);
    int region;
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= SEG_W'(seg);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seg_now = seg;
    n_settings++;
    // every entry a query can touch gets written before it is read
    region = (seg_now + 1) * (seg_now + 1);
    for (int i = 0; i < region; i++) begin
      if (!written[i]) store(GRID_AW'(i), rand_height());
    end
  endtask

  initial begin : result_sink
    int run, mode;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        run = $urandom_range(4, 60);
        for (int k = 0; k < run && !hold_req; k++) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= k[2];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) quiet = 0;
      else quiet++;
    end
    $display("no handshake for %0d cycles, %0d heights still due", quiet, outstanding);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int region;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 2x2 grid at reset setting: extreme corners
    store(GRID_AW'(0), S_MAX);
    store(GRID_AW'(1), S_MIN);
    store(GRID_AW'(2), '0);
    store(GRID_AW'(3), ONE_M);
    store(GRID_AW'(GRID_DEPTH - 1), -1);
    query('0, '0, '0);
    query(TILE_Q / 2, TILE_Q / 2, '0);
    query(TILE_Q, TILE_Q, '0);
    query(TILE_Q - 1, '0, S_MAX);
    query('0, '0, S_MAX);
    query(-1, -1, '0);
    query(S_MIN, S_MIN, S_MIN);
    query(S_MAX, S_MAX, S_MAX);
    query(TILE_Q / 2, '0, S_MIN);
    query('0, TILE_Q - 1, S_MIN);
    query(300, 300, 1);
    query(TILE_Q + (5 << FRAC_W), -(7 << FRAC_W), '0);
    // write then read back-to-back
    store(GRID_AW'(0), 32'sh1234_5678);
    query('0, '0, '0);
    store(GRID_AW'(2), S_MIN);
    query('0, TILE_Q, -1);

    foreach (seg_plan[p]) begin
      set_segments(seg_plan[p]);
      if (seg_plan[p] == 17) hold_req = 1'b1;
      region = (seg_now + 1) * (seg_now + 1);
      repeat (RANDOM_ITEMS / $size(seg_plan)) begin
        if ($urandom_range(0, 9) < 3) begin
          if ($urandom_range(0, 1) == 1) store(GRID_AW'($urandom_range(0, region - 1)),
                                              rand_height());
          else store(GRID_AW'($urandom), rand_height());
        end else begin
          query(rand_coord(), rand_coord(), rand_height());
        end
      end
    end
    settle();

    $display("run covered %0d items: %0d height queries and %0d grid writes over %0d grid sizes",
             n_query + n_write, n_query, n_write, n_settings);
    $display("%0d heights compared, including one %0d-cycle output hold-off", checked,
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
rtl/hbs_pkg.sv
rtl/hbs_axis_scale.sv
rtl/hbs_grid_mem.sv
rtl/heightmap_bilinear_sampler_core.sv
dv/hbs_height_checker.sv
dv/heightmap_bilinear_sampler_core_test.sv
